// File: hw/rtl/multi_pattern_occurrence_counter_top_defines.svh
// Assertion macros used by the multi-pattern occurrence counter top level.
`ifndef MULTI_PATTERN_OCCURRENCE_COUNTER_TOP_DEFINES_SVH
`define MULTI_PATTERN_OCCURRENCE_COUNTER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MPOC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MPOC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/mpoc_pkg.sv
// Package with the types and constants of the multi-pattern occurrence counter.
package mpoc_pkg;

  localparam int MAX_NODES_DEF  = 4096;
  localparam int COUNT_BITS_DEF = 32;
  localparam int MAX_PATTERNS   = 64;
  localparam int ALPHABET       = 26;

  localparam int OP_W     = 3;
  localparam int SYM_W    = 5;
  localparam int ID_W     = 6;
  localparam int STATUS_W = 2;
  localparam int RCOUNT_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 3'd0,
    OP_LETTER = 3'd1,
    OP_END    = 3'd2,
    OP_BUILD  = 3'd3,
    OP_TEXT   = 3'd4,
    OP_READ   = 3'd5
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_UNKNOWN = 2'd2
  } status_e;

endpackage

// File: hw/rtl/multi_pattern_occurrence_counter_top.sv
// Top level of the multi-pattern occurrence counter (Aho-Corasick engine).
// Every input word carries an opcode and yields exactly one result word. The
// trie, failure links, hit counts, pattern map and build queue live in RAMs
// with a registered read port each, so all work is a sequence of memory steps
// and one word is processed at a time. A text letter also walks the failure
// chain of the reached node and counts a hit on every node of it. Build scans
// the root's edges, then every queued trie node in breadth-first order. Clear
// sweeps all MAX_NODES*ALPHABET entries of the goto RAM (106496 by default),
// one entry a cycle; the same pass runs after reset before the first word is
// taken. A finished result sits in an output register, so the next word is
// taken while it waits.
`include "multi_pattern_occurrence_counter_top_defines.svh"

module multi_pattern_occurrence_counter_top
  import mpoc_pkg::*;
#(
  parameter int MAX_NODES  = MAX_NODES_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // opcode[2:0], symbol[7:3], pattern_id[13:8], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // status[1:0], match_count[33:2], zero pad
);

  localparam int NODE_W     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int NU_W       = NODE_W + 1;
  localparam int GOTO_DEPTH = MAX_NODES * ALPHABET;
  localparam int EA_W       = $clog2(GOTO_DEPTH);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_LET_A, S_LET_B, S_TX_A, S_TX_B, S_TX_C,
    S_RD_A, S_RD_B, S_RD_C, S_B0_A, S_B0_B, S_POP, S_BU, S_BF,
    S_E1, S_E2, S_E3, S_RESP
  } state_e;

  state_e                  state_q;
  logic                    init_q;
  opcode_e                 op_q;
  logic [ID_W-1:0]         id_q;
  logic [NODE_W-1:0]       cursor_q, ms_q, j_q, u_q, f_q, child_q;
  logic [NU_W-1:0]         nodes_q, head_q, tail_q;
  logic                    built_q;
  logic [MAX_PATTERNS-1:0] known_q;
  logic [EA_W-1:0]         clr_q, ea_q;
  logic [SYM_W-1:0]        c_q;
  status_e                 res_status_q, m_status_q;
  logic [RCOUNT_W-1:0]     res_count_q, m_count_q;
  logic                    m_valid_q;

  opcode_e          in_op;
  logic [SYM_W-1:0] in_sym;
  logic [ID_W-1:0]  in_id;
  logic             in_acc;
  logic             resp_fire;

  assign in_op  = opcode_e'(s_tdata[2:0]);
  assign in_sym = s_tdata[7:3];
  assign in_id  = s_tdata[13:8];
  assign s_tready = (state_q == S_IDLE);
  assign in_acc = s_tvalid && s_tready;
  // The output register loads when it is empty or its word leaves this cycle.
  assign resp_fire = (state_q == S_RESP) && (!m_valid_q || m_tready);

  // Memory ports.
  logic                  g_we, f_we, h_we, q_we, p_we;
  logic [EA_W-1:0]       g_waddr, g_raddr;
  logic [NODE_W-1:0]     g_wdata, g_rdata;
  logic [NODE_W-1:0]     f_waddr, f_raddr, f_wdata, f_rdata;
  logic [NODE_W-1:0]     h_waddr, h_raddr;
  logic [COUNT_BITS-1:0] h_wdata, h_rdata, h_inc;
  logic [NODE_W-1:0]     q_waddr, q_raddr, q_wdata, q_rdata;
  logic [ID_W-1:0]       p_waddr, p_raddr;
  logic [NODE_W-1:0]     p_wdata, p_rdata;
  logic [63:0]           h_wide;
  logic [RCOUNT_W-1:0]   h_sat;

  function automatic logic [EA_W-1:0] edge_addr(logic [NODE_W-1:0] n, logic [SYM_W-1:0] s);
    return EA_W'(n * ALPHABET) + EA_W'(s);
  endfunction

  assign h_inc  = (h_rdata == '1) ? h_rdata : h_rdata + 1'b1;
  assign h_wide = 64'(h_rdata);
  assign h_sat  = (|h_wide[63:32]) ? '1 : h_wide[31:0];

  always_comb begin
    g_we = 1'b0; g_waddr = clr_q; g_wdata = '0; g_raddr = ea_q;
    f_we = 1'b0; f_waddr = clr_q[NODE_W-1:0]; f_wdata = '0; f_raddr = g_rdata;
    h_we = 1'b0; h_waddr = clr_q[NODE_W-1:0]; h_wdata = '0; h_raddr = g_rdata;
    q_we = 1'b0; q_waddr = tail_q[NODE_W-1:0]; q_wdata = g_rdata;
    q_raddr = head_q[NODE_W-1:0];
    p_we = 1'b0; p_waddr = in_id; p_wdata = cursor_q; p_raddr = id_q;
    unique case (state_q)
      S_CLEAR: begin
        g_we = 1'b1;
        f_we = (clr_q < EA_W'(MAX_NODES));
        h_we = f_we;
      end
      S_IDLE: begin
        p_we = in_acc && (in_op == OP_END) && !built_q;
      end
      S_LET_B: begin
        g_we    = (g_rdata == '0) && (nodes_q < NU_W'(MAX_NODES));
        g_waddr = ea_q;
        g_wdata = nodes_q[NODE_W-1:0];
      end
      S_TX_C: begin
        h_we    = 1'b1;
        h_waddr = j_q;
        h_wdata = h_inc;
        h_raddr = f_rdata;
        f_raddr = f_rdata;
      end
      S_RD_B: h_raddr = p_rdata;
      S_B0_A: g_raddr = EA_W'(c_q);
      S_B0_B: q_we = (g_rdata != '0);
      S_BU:   f_raddr = q_rdata;
      S_E1:   g_raddr = edge_addr(u_q, c_q);
      S_E2:   g_raddr = edge_addr(f_q, c_q);
      S_E3: begin
        if (child_q != '0) begin
          f_we    = 1'b1;
          f_waddr = child_q;
          f_wdata = g_rdata;
          q_we    = 1'b1;
          q_wdata = child_q;
        end else begin
          g_we    = 1'b1;
          g_waddr = edge_addr(u_q, c_q);
          g_wdata = g_rdata;
        end
      end
      default: ;
    endcase
  end

  mpoc_ram #(.WIDTH(NODE_W), .DEPTH(GOTO_DEPTH)) u_goto (
    .clk_i, .we_i(g_we), .waddr_i(g_waddr), .wdata_i(g_wdata),
    .raddr_i(g_raddr), .rdata_o(g_rdata)
  );
  mpoc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_fail (
    .clk_i, .we_i(f_we), .waddr_i(f_waddr), .wdata_i(f_wdata),
    .raddr_i(f_raddr), .rdata_o(f_rdata)
  );
  mpoc_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_NODES)) u_hits (
    .clk_i, .we_i(h_we), .waddr_i(h_waddr), .wdata_i(h_wdata),
    .raddr_i(h_raddr), .rdata_o(h_rdata)
  );
  mpoc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue (
    .clk_i, .we_i(q_we), .waddr_i(q_waddr), .wdata_i(q_wdata),
    .raddr_i(q_raddr), .rdata_o(q_rdata)
  );
  mpoc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_PATTERNS)) u_pend (
    .clk_i, .we_i(p_we), .waddr_i(p_waddr), .wdata_i(p_wdata),
    .raddr_i(p_raddr), .rdata_o(p_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      init_q    <= 1'b1;
      op_q      <= OP_CLEAR;
      clr_q     <= '0;
      nodes_q   <= NU_W'(1);
      cursor_q  <= '0;
      ms_q      <= '0;
      built_q   <= 1'b0;
      known_q   <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      c_q       <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (resp_fire) begin
        m_valid_q <= 1'b1;
      end else if (m_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == EA_W'(GOTO_DEPTH - 1)) begin
            init_q  <= 1'b0;
            state_q <= init_q ? S_IDLE : S_RESP;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            op_q         <= in_op;
            id_q         <= in_id;
            res_status_q <= ST_OK;
            res_count_q  <= '0;
            state_q      <= S_RESP;
            unique case (in_op)
              OP_CLEAR: begin
                known_q  <= '0;
                nodes_q  <= NU_W'(1);
                cursor_q <= '0;
                ms_q     <= '0;
                built_q  <= 1'b0;
                clr_q    <= '0;
                state_q  <= S_CLEAR;
              end
              OP_LETTER: begin
                if (!built_q && (in_sym < SYM_W'(ALPHABET))) begin
                  ea_q    <= edge_addr(cursor_q, in_sym);
                  state_q <= S_LET_A;
                end
              end
              OP_END: begin
                if (7'(in_id) >= 7'(MAX_PATTERNS)) begin
                  res_status_q <= ST_UNKNOWN;
                end else if (!built_q) begin
                  known_q[in_id] <= 1'b1;
                  cursor_q       <= '0;
                end
              end
              OP_BUILD: begin
                if (!built_q) begin
                  c_q     <= '0;
                  head_q  <= '0;
                  tail_q  <= '0;
                  state_q <= S_B0_A;
                end
              end
              OP_TEXT: begin
                if (in_sym < SYM_W'(ALPHABET)) begin
                  ea_q    <= edge_addr(ms_q, in_sym);
                  state_q <= S_TX_A;
                end
              end
              OP_READ: begin
                if ((7'(in_id) >= 7'(MAX_PATTERNS)) || !known_q[in_id]) begin
                  res_status_q <= ST_UNKNOWN;
                end else begin
                  state_q <= S_RD_A;
                end
              end
              default: ;
            endcase
          end
        end
        S_LET_A: state_q <= S_LET_B;
        S_LET_B: begin
          if (g_rdata != '0) begin
            cursor_q <= g_rdata;
          end else if (nodes_q < NU_W'(MAX_NODES)) begin
            cursor_q <= nodes_q[NODE_W-1:0];
            nodes_q  <= nodes_q + 1'b1;
          end else begin
            res_status_q <= ST_FULL;
          end
          state_q <= S_RESP;
        end
        S_TX_A: state_q <= S_TX_B;
        S_TX_B: begin
          ms_q    <= g_rdata;
          j_q     <= g_rdata;
          state_q <= (g_rdata == '0) ? S_RESP : S_TX_C;
        end
        S_TX_C: begin
          // The failure link is always shallower, so the next read never hits
          // the entry written in this cycle.
          j_q <= f_rdata;
          if (f_rdata == '0) begin
            state_q <= S_RESP;
          end
        end
        S_RD_A: state_q <= S_RD_B;
        S_RD_B: state_q <= S_RD_C;
        S_RD_C: begin
          res_count_q <= h_sat;
          state_q     <= S_RESP;
        end
        S_B0_A: state_q <= S_B0_B;
        S_B0_B: begin
          if (g_rdata != '0) begin
            tail_q <= tail_q + 1'b1;
          end
          if (c_q == SYM_W'(ALPHABET - 1)) begin
            state_q <= S_POP;
          end else begin
            c_q     <= c_q + 1'b1;
            state_q <= S_B0_A;
          end
        end
        S_POP: begin
          if (head_q == tail_q) begin
            built_q <= 1'b1;
            ms_q    <= '0;
            state_q <= S_RESP;
          end else begin
            state_q <= S_BU;
          end
        end
        S_BU: begin
          u_q     <= q_rdata;
          head_q  <= head_q + 1'b1;
          state_q <= S_BF;
        end
        S_BF: begin
          f_q     <= f_rdata;
          c_q     <= '0;
          state_q <= S_E1;
        end
        S_E1: state_q <= S_E2;
        S_E2: begin
          child_q <= g_rdata;
          state_q <= S_E3;
        end
        S_E3: begin
          if (child_q != '0) begin
            tail_q <= tail_q + 1'b1;
          end
          if (c_q == SYM_W'(ALPHABET - 1)) begin
            state_q <= S_POP;
          end else begin
            c_q     <= c_q + 1'b1;
            state_q <= S_E1;
          end
        end
        S_RESP: begin
          if (resp_fire) begin
            m_status_q <= res_status_q;
            m_count_q  <= res_count_q;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_tvalid = m_valid_q;
  assign m_tdata  = {6'd0, m_count_q, m_status_q};

  `MPOC_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, s_tvalid && s_tready, !s_tready,
    "block took a word while the previous one was still in work")
  `MPOC_ASSERT_IMPLY(a_chain_nonroot, clk_i, rst_ni, state_q == S_TX_C, j_q != '0,
    "failure chain walk reached the root node")
  `MPOC_ASSERT_IMPLY(a_built_by_build, clk_i, rst_ni, $rose(built_q), op_q == OP_BUILD,
    "automaton marked built outside a build")

endmodule

// File: hw/rtl/mpoc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module mpoc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: bench/tb_top.sv
// Self-checking testbench for the multi-pattern occurrence counter.
`timescale 1ns / 1ps

module tb_top;
  import mpoc_pkg::*;

  localparam int NODES     = MAX_NODES_DEF;
  localparam int EDGES     = NODES * ALPHABET;
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam logic [31:0] HIT_TOP  = 32'hFFFF_FFFF;

  typedef struct packed {
    status_e     st;
    logic [31:0] cnt;
  } outcome_t;

  typedef struct {
    logic [2:0] op;
    logic [4:0] sym;
    logic [5:0] id;
    bit         fixed;
    status_e    st;
    logic [31:0] cnt;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // opcode[2:0], symbol[7:3], pattern_id[13:8], zero pad
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // status[1:0], match_count[33:2], zero pad

  multi_pattern_occurrence_counter_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // Own copy of the automaton.
  int unsigned trie_next [EDGES];
  int unsigned fail_of   [NODES];
  logic [31:0] hits      [NODES];
  int unsigned end_node  [64];
  bit          id_known  [64];
  int unsigned used_nodes, cursor, walk_at;
  bit          links_built;

  outcome_t pending_q[$];
  int errors = 0, words_sent = 0, words_checked = 0, nonzero_reads = 0, full_seen = 0;
  bit send_calm = 0, recv_calm = 0;

  function automatic void wipe_automaton();
    for (int i = 0; i < EDGES; i++) trie_next[i] = 0;
    for (int i = 0; i < NODES; i++) begin
      fail_of[i] = 0;
      hits[i] = '0;
    end
    for (int i = 0; i < 64; i++) id_known[i] = 0;
    used_nodes = 1;
    cursor = 0;
    walk_at = 0;
    links_built = 0;
  endfunction

  function automatic void build_links();
    int unsigned q[$];
    int unsigned u, f, child, via;
    for (int c = 0; c < ALPHABET; c++) begin
      child = trie_next[c];
      if (child != 0) begin
        fail_of[child] = 0;
        q = {q, child};
      end
    end
    while (q.size() > 0) begin
      u = q.pop_front();
      f = fail_of[u];
      for (int c = 0; c < ALPHABET; c++) begin
        child = trie_next[u*ALPHABET + c];
        via = trie_next[f*ALPHABET + c];
        if (child != 0) begin
          fail_of[child] = via;
          q = {q, child};
        end else begin
          trie_next[u*ALPHABET + c] = via;
        end
      end
    end
    links_built = 1;
    walk_at = 0;
  endfunction

  function automatic outcome_t apply_word(logic [2:0] op, logic [4:0] sym, logic [5:0] id);
    outcome_t r;
    int unsigned e, j, steps;
    r.st = ST_OK;
    r.cnt = '0;
    case (op)
      OP_CLEAR: wipe_automaton();
      OP_LETTER: begin
        if (!links_built && sym < ALPHABET) begin
          e = cursor*ALPHABET + sym;
          if (trie_next[e] != 0) begin
            cursor = trie_next[e];
          end else if (used_nodes < NODES) begin
            trie_next[e] = used_nodes;
            cursor = used_nodes;
            used_nodes++;
          end else begin
            r.st = ST_FULL;
          end
        end
      end
      OP_END: begin
        if (!links_built) begin
          end_node[id] = cursor;
          id_known[id] = 1;
          cursor = 0;
        end
      end
      OP_BUILD: if (!links_built) build_links();
      OP_TEXT: begin
        if (sym < ALPHABET) begin
          walk_at = trie_next[walk_at*ALPHABET + sym];
          j = walk_at;
          steps = 0;
          while (j != 0 && steps < NODES) begin
            if (hits[j] != HIT_TOP) hits[j]++;
            j = fail_of[j];
            steps++;
          end
        end
      end
      OP_READ: begin
        if (!id_known[id]) r.st = ST_UNKNOWN;
        else r.cnt = hits[end_node[id]];
      end
      default: ;
    endcase
    return r;
  endfunction

  initial begin
    forever begin
      #6 clk_i = ~clk_i;
    end
  end

  initial begin
    #36_000_000;
    $display("multi_pattern_occurrence_counter_top verification failed");
    $finish;
  end

  // Sender: entered and left just after a falling edge.
  task automatic send_word(logic [2:0] op, logic [4:0] sym, logic [5:0] id,
                           bit fixed = 0, outcome_t want = '0);
    int gap;
    outcome_t r;
    gap = send_calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, id, sym, op};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    r = apply_word(op, sym, id);
    if (fixed) r = want;
    pending_q = {pending_q, r};
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_q.size() > 0) @(negedge clk_i);
  endtask

  // Receiver and checker.
  initial begin
    int gap;
    outcome_t want;
    @(negedge clk_i);
    forever begin
      gap = recv_calm ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_tvalid) @(posedge clk_i);
      words_checked++;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word status=%0d count=%0d", $time,
                 m_tdata[1:0], m_tdata[33:2]);
      end else begin
        want = pending_q.pop_front();
        if (m_tdata[1:0] !== want.st) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want.st, m_tdata[1:0]);
        end
        if (m_tdata[33:2] !== want.cnt) begin
          errors++;
          $display("%0t: match_count expected %0d actual %0d", $time, want.cnt,
                   m_tdata[33:2]);
        end
        if (want.st == ST_FULL) full_seen++;
        if (want.cnt != 0) nonzero_reads++;
      end
      @(negedge clk_i);
    end
  end

  task automatic run_session(int n_items);
    int alpha, npat, len, r, sent;
    logic [5:0] ids[$];
    logic [5:0] pid;
    drain();
    send_word(OP_CLEAR, 5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)));
    alpha = $urandom_range(2, 26);
    npat = $urandom_range(1, 12);
    sent = 1;
    for (int p = 0; p < npat; p++) begin
      len = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
      for (int k = 0; k < len; k++) begin
        r = $urandom_range(0, 19);
        if (r == 0) send_word(OP_LETTER, 5'($urandom_range(26, 31)), 6'($urandom));
        else if (r == 1) send_word(OP_READ, 5'($urandom), 6'($urandom_range(0, 63)));
        else if (r == 2) send_word(OP_TEXT, 5'($urandom_range(0, 31)), 6'($urandom));
        send_word(OP_LETTER, 5'($urandom_range(0, alpha - 1)), 6'($urandom));
        sent += 2;
      end
      pid = 6'($urandom_range(0, 63));
      ids = {ids, pid};
      send_word(OP_END, 5'($urandom), pid);
      sent++;
    end
    send_word(OP_BUILD, 5'($urandom), 6'($urandom));
    sent++;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      send_calm = (sent % 120) < 30;
      if (r < 68) begin
        send_word(OP_TEXT, 5'(($urandom_range(0, 29) == 0) ? $urandom_range(26, 31)
                                                             : $urandom_range(0, alpha - 1)),
                  6'($urandom));
      end else if (r < 86) begin
        pid = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                          : ids[$urandom_range(0, ids.size() - 1)];
        send_word(OP_READ, 5'($urandom), pid);
      end else if (r < 91) begin
        send_word(OP_LETTER, 5'($urandom_range(0, 31)), 6'($urandom));
      end else if (r < 94) begin
        send_word(OP_END, 5'($urandom), 6'($urandom_range(0, 63)));
      end else if (r < 98) begin
        send_word(($urandom_range(0, 1) == 0) ? OP_SPARE6 : OP_SPARE7, 5'($urandom),
                  6'($urandom));
      end else begin
        send_word(OP_BUILD, 5'($urandom), 6'($urandom));
      end
      sent++;
    end
    send_calm = 0;
    foreach (ids[i]) send_word(OP_READ, 5'($urandom), ids[i]);
  endtask

  initial begin
    row_t rows[$];
    wipe_automaton();
    // Right after reset every id is unknown and stray codes are harmless.
    rows = '{
      '{OP_READ,   5'd0,  6'd0,  1, ST_UNKNOWN, 32'd0},
      '{OP_READ,   5'd31, 6'd63, 1, ST_UNKNOWN, 32'd0},
      '{OP_LETTER, 5'd31, 6'd0,  1, ST_OK,      32'd0},
      '{OP_TEXT,   5'd26, 6'd0,  1, ST_OK,      32'd0},
      '{OP_SPARE6, 5'd0,  6'd0,  1, ST_OK,      32'd0},
      '{OP_SPARE7, 5'd31, 6'd63, 1, ST_OK,      32'd0},
      '{OP_LETTER, 5'd7,  6'd0,  0, ST_OK,      32'd0},
      '{OP_LETTER, 5'd4,  6'd0,  0, ST_OK,      32'd0},
      '{OP_END,    5'd0,  6'd0,  0, ST_OK,      32'd0},
      '{OP_LETTER, 5'd18, 6'd0,  0, ST_OK,      32'd0},
      '{OP_LETTER, 5'd7,  6'd0,  0, ST_OK,      32'd0},
      '{OP_LETTER, 5'd4,  6'd0,  0, ST_OK,      32'd0},
      '{OP_END,    5'd0,  6'd1,  0, ST_OK,      32'd0},
      '{OP_LETTER, 5'd25, 6'd0,  0, ST_OK,      32'd0},
      '{OP_END,    5'd0,  6'd2,  0, ST_OK,      32'd0},
      '{OP_END,    5'd0,  6'd63, 0, ST_OK,      32'd0},
      '{OP_TEXT,   5'd7,  6'd0,  0, ST_OK,      32'd0},
      '{OP_TEXT,   5'd4,  6'd0,  0, ST_OK,      32'd0},
      '{OP_BUILD,  5'd0,  6'd0,  0, ST_OK,      32'd0},
      '{OP_TEXT,   5'd18, 6'd0,  0, ST_OK,      32'd0},
      '{OP_TEXT,   5'd7,  6'd0,  0, ST_OK,      32'd0},
      '{OP_TEXT,   5'd4,  6'd0,  0, ST_OK,      32'd0},
      '{OP_LETTER, 5'd1,  6'd0,  0, ST_OK,      32'd0},
      '{OP_END,    5'd0,  6'd5,  0, ST_OK,      32'd0},
      '{OP_BUILD,  5'd0,  6'd0,  0, ST_OK,      32'd0},
      '{OP_READ,   5'd0,  6'd0,  0, ST_OK,      32'd0},
      '{OP_READ,   5'd0,  6'd1,  0, ST_OK,      32'd0},
      '{OP_READ,   5'd0,  6'd63, 1, ST_OK,      32'd0},
      '{OP_READ,   5'd0,  6'd5,  1, ST_UNKNOWN, 32'd0}
    };
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (rows[i]) send_word(rows[i].op, rows[i].sym, rows[i].id, rows[i].fixed,
                                '{rows[i].st, rows[i].cnt});
    for (int s = 0; s < 3; s++) begin
      recv_calm = (s == 1);
      run_session(460);
    end
    recv_calm = 0;
    drain();
    repeat (200) @(posedge clk_i);
    $display("Sent %0d words: a directed table and three random sessions; checked %0d results,",
             words_sent, words_checked);
    $display("%0d nonzero counts and %0d trie-full answers, %0d errors.",
             nonzero_reads, full_seen, errors);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("multi_pattern_occurrence_counter_top verification clean");
    end else begin
      $display("multi_pattern_occurrence_counter_top verification failed");
    end
    $finish;
  end

endmodule
